// ----- hw/rtl/pfd_pkg.sv -----
// ----------------------------------------------------------------------------
// pfd_pkg: shared types and codes of the protobuf frame field decoder
// Event codes, decoder phases and the event words that pass from the
// decoder front end through the queue to the output stage.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam logic [3:0] EV_SCALAR   = 4'd0;
  localparam logic [3:0] EV_PSTART   = 4'd1;
  localparam logic [3:0] EV_PBYTE    = 4'd2;
  localparam logic [3:0] EV_HSTART   = 4'd3;
  localparam logic [3:0] EV_KSTART   = 4'd4;
  localparam logic [3:0] EV_KBYTE    = 4'd5;
  localparam logic [3:0] EV_VSTART   = 4'd6;
  localparam logic [3:0] EV_VBYTE    = 4'd7;
  localparam logic [3:0] EV_HDONE    = 4'd8;
  localparam logic [3:0] EV_END      = 4'd9;

  localparam logic [2:0] FC_SKIP     = 3'd0;
  localparam logic [2:0] FC_HEADER   = 3'd5;
  localparam logic [2:0] FC_PAYLOAD  = 3'd6;

  localparam logic [1:0] SC_SKIP     = 2'd0;
  localparam logic [1:0] SC_KEY      = 2'd1;
  localparam logic [1:0] SC_VALUE    = 2'd2;

  localparam logic [2:0] WT_VARINT   = 3'd0;
  localparam logic [2:0] WT_FIXED64  = 3'd1;
  localparam logic [2:0] WT_LEN      = 3'd2;
  localparam logic [2:0] WT_FIXED32  = 3'd5;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam int TDATA_W = 88;

  typedef enum logic [1:0] {
    TP_TAG,
    TP_VARINT,
    TP_LEN,
    TP_BODY
  } top_phase_t;

  typedef enum logic [2:0] {
    SP_IDLE,
    SP_TAG,
    SP_VARINT,
    SP_LEN,
    SP_BODY
  } sub_phase_t;

  typedef struct packed {
    logic [3:0]  ev;
    logic [2:0]  fid;
    logic [63:0] value;
    logic [7:0]  ob;
    logic [3:0]  hidx;
    logic        hstored;
    logic        status;
    logic        last;
  } pfd_event_t;

  // up to two events caused by one input word
  typedef struct packed {
    logic       two;
    pfd_event_t e0;
    pfd_event_t e1;
  } pfd_bundle_t;

endpackage

// ----- hw/rtl/pfd_front.sv -----
// ----------------------------------------------------------------------------
// pfd_front: wire format decoder front end
// Accepts one input word per cycle while the queue is not full, walks the
// tag, varint, length and body phases of the frame and of nested headers,
// and pushes the resulting events as one bundle into the event queue.
// ----------------------------------------------------------------------------
module pfd_front import pfd_pkg::*; #(
  parameter int MAX_HEADERS = 8,
  parameter int KEY_BUF     = 64,
  parameter int VALUE_BUF   = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  logic        q_full,
  output logic        push,
  output pfd_bundle_t bundle
);

  top_phase_t  top_phase, top_phase_next;
  sub_phase_t  sub_phase, sub_phase_next;
  logic [2:0]  field_class, field_class_next;
  logic [1:0]  sub_class, sub_class_next;
  logic [63:0] varint_acc, varint_acc_next;
  logic [3:0]  varint_count, varint_count_next;
  logic [31:0] top_remaining, top_remaining_next;
  logic [31:0] sub_remaining, sub_remaining_next;
  logic [31:0] sub_field_remaining, sub_field_remaining_next;
  logic [3:0]  header_total, header_total_next;
  logic [7:0]  chars_written, chars_written_next;
  logic        error_latch, error_latch_next;

  logic        fire;
  logic [63:0] vacc;
  logic [63:0] vbase;
  logic [3:0]  vcnt;
  logic        vdone;
  logic        vbad;
  logic [31:0] num;
  logic [2:0]  wire_type;
  logic [31:0] top_dec;
  logic [31:0] sub_dec;
  logic [31:0] sfr_dec;
  logic [31:0] fix_w;
  logic        hb_err;
  pfd_event_t  ev0, ev1;
  logic        has0, has1;

  function automatic pfd_event_t mk(input logic [3:0] code, input logic [2:0] fid,
                                    input logic [63:0] val, input logic [7:0] ob,
                                    input logic hdr, input logic [3:0] total);
    pfd_event_t e;
    e.ev      = code;
    e.fid     = fid;
    e.value   = val;
    e.ob      = ob;
    e.hidx    = hdr ? total : 4'd0;
    e.hstored = hdr && (total < 4'(MAX_HEADERS));
    e.status  = 1'b0;
    e.last    = 1'b0;
    return e;
  endfunction

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  // varint step on the current byte
  always_comb begin
    vbase = (varint_count == 4'd0) ? 64'd0 : varint_acc;
    if (varint_count < 4'd9) begin
      vacc = vbase | ({57'd0, data_byte[6:0]} << (7'(varint_count) * 7'd7));
    end else begin
      vacc = vbase | {data_byte[0], 63'd0};
    end
    vdone     = !data_byte[7];
    vbad      = data_byte[7] && (varint_count == 4'd9);
    vcnt      = vdone ? 4'd0 : varint_count + 4'd1;
    num       = vacc[34:3];
    wire_type = vacc[2:0];
    fix_w     = (wire_type == WT_FIXED64) ? 32'd8 : 32'd4;
  end

  always_comb begin
    top_phase_next           = top_phase;
    sub_phase_next           = sub_phase;
    field_class_next         = field_class;
    sub_class_next           = sub_class;
    varint_acc_next          = varint_acc;
    varint_count_next        = varint_count;
    top_remaining_next       = top_remaining;
    sub_remaining_next       = sub_remaining;
    sub_field_remaining_next = sub_field_remaining;
    header_total_next        = header_total;
    chars_written_next       = chars_written;
    error_latch_next         = error_latch;
    ev0     = '0;
    ev1     = '0;
    has0    = 1'b0;
    has1    = 1'b0;
    hb_err  = 1'b0;
    top_dec = (top_remaining != 32'd0) ? top_remaining - 32'd1 : top_remaining;
    sub_dec = sub_remaining - 32'd1;
    sfr_dec = (sub_field_remaining != 32'd0) ? sub_field_remaining - 32'd1
                                             : sub_field_remaining;

    if (fire) begin
      if (kind) begin
        ev0 = mk(EV_END, 3'd0, 64'd0, 8'd0, 1'b0, header_total);
        ev0.status = error_latch || (top_phase != TP_TAG) || (varint_count != 4'd0);
        has0 = 1'b1;
        top_phase_next           = TP_TAG;
        sub_phase_next           = SP_IDLE;
        field_class_next         = FC_SKIP;
        sub_class_next           = SC_SKIP;
        varint_acc_next          = '0;
        varint_count_next        = '0;
        top_remaining_next       = '0;
        sub_remaining_next       = '0;
        sub_field_remaining_next = '0;
        header_total_next        = '0;
        chars_written_next       = '0;
        error_latch_next         = 1'b0;
      end else if (!error_latch) begin
        case (top_phase)
          TP_TAG: begin
            varint_acc_next   = vacc;
            varint_count_next = vcnt;
            if (vbad) begin
              error_latch_next = 1'b1;
            end else if (vdone) begin
              case (wire_type)
                WT_VARINT: begin
                  field_class_next = (num >= 32'd1 && num <= 32'd4) ? num[2:0] : FC_SKIP;
                  top_phase_next   = TP_VARINT;
                end
                WT_LEN: begin
                  field_class_next = (num == 32'd5) ? FC_HEADER :
                                     (num == 32'd8) ? FC_PAYLOAD : FC_SKIP;
                  top_phase_next   = TP_LEN;
                end
                WT_FIXED64, WT_FIXED32: begin
                  field_class_next   = FC_SKIP;
                  top_remaining_next = fix_w;
                  top_phase_next     = TP_BODY;
                end
                default: begin
                  error_latch_next = 1'b1;
                end
              endcase
            end
          end
          TP_VARINT: begin
            varint_acc_next   = vacc;
            varint_count_next = vcnt;
            if (vbad) begin
              error_latch_next = 1'b1;
            end else if (vdone) begin
              if (field_class inside {[3'd1:3'd4]}) begin
                ev0  = mk(EV_SCALAR, field_class, vacc, 8'd0, 1'b0, header_total);
                has0 = 1'b1;
              end
              field_class_next = FC_SKIP;
              top_phase_next   = TP_TAG;
            end
          end
          TP_LEN: begin
            varint_acc_next   = vacc;
            varint_count_next = vcnt;
            if (vbad) begin
              error_latch_next = 1'b1;
            end else if (vdone) begin
              if (vacc[63:32] != 32'd0) begin
                error_latch_next = 1'b1;
              end else if (field_class == FC_HEADER) begin
                ev0  = mk(EV_HSTART, 3'd0, vacc, 8'd0, 1'b1, header_total);
                has0 = 1'b1;
                if (vacc == 64'd0) begin
                  ev1  = mk(EV_HDONE, 3'd0, 64'd0, 8'd0, 1'b1, header_total);
                  has1 = 1'b1;
                  if (header_total < 4'(MAX_HEADERS)) header_total_next = header_total + 4'd1;
                  top_phase_next   = TP_TAG;
                  field_class_next = FC_SKIP;
                  sub_phase_next   = SP_IDLE;
                  sub_class_next   = SC_SKIP;
                end else begin
                  sub_remaining_next = vacc[31:0];
                  sub_phase_next     = SP_TAG;
                  sub_class_next     = SC_SKIP;
                  top_phase_next     = TP_BODY;
                end
              end else begin
                if (field_class == FC_PAYLOAD) begin
                  ev0  = mk(EV_PSTART, 3'd0, vacc, 8'd0, 1'b0, header_total);
                  has0 = 1'b1;
                end
                top_remaining_next = vacc[31:0];
                if (vacc == 64'd0) begin
                  top_phase_next   = TP_TAG;
                  field_class_next = FC_SKIP;
                end else begin
                  top_phase_next   = TP_BODY;
                end
              end
            end
          end
          default: begin
            if (field_class == FC_HEADER) begin
              sub_remaining_next = sub_dec;
              case (sub_phase)
                SP_TAG: begin
                  varint_acc_next   = vacc;
                  varint_count_next = vcnt;
                  if (vbad) begin
                    hb_err = 1'b1;
                  end else if (vdone) begin
                    case (wire_type)
                      WT_VARINT: sub_phase_next = SP_VARINT;
                      WT_LEN: begin
                        sub_class_next = (num == 32'd1) ? SC_KEY :
                                         (num == 32'd2) ? SC_VALUE : SC_SKIP;
                        sub_phase_next = SP_LEN;
                      end
                      WT_FIXED64, WT_FIXED32: begin
                        if (sub_dec < fix_w) begin
                          hb_err = 1'b1;
                        end else begin
                          sub_field_remaining_next = fix_w;
                          sub_class_next           = SC_SKIP;
                          sub_phase_next           = SP_BODY;
                        end
                      end
                      default: hb_err = 1'b1;
                    endcase
                  end
                end
                SP_VARINT: begin
                  varint_acc_next   = vacc;
                  varint_count_next = vcnt;
                  if (vbad) begin
                    hb_err = 1'b1;
                  end else if (vdone) begin
                    sub_phase_next = SP_TAG;
                  end
                end
                SP_LEN: begin
                  varint_acc_next   = vacc;
                  varint_count_next = vcnt;
                  if (vbad) begin
                    hb_err = 1'b1;
                  end else if (vdone) begin
                    if (vacc > {32'd0, sub_dec}) begin
                      hb_err = 1'b1;
                    end else begin
                      sub_field_remaining_next = vacc[31:0];
                      chars_written_next       = 8'd0;
                      if (sub_class == SC_KEY) begin
                        ev0  = mk(EV_KSTART, 3'd0, vacc, 8'd0, 1'b1, header_total);
                        has0 = 1'b1;
                      end else if (sub_class == SC_VALUE) begin
                        ev0  = mk(EV_VSTART, 3'd0, vacc, 8'd0, 1'b1, header_total);
                        has0 = 1'b1;
                      end
                      sub_phase_next = (vacc == 64'd0) ? SP_TAG : SP_BODY;
                    end
                  end
                end
                default: begin
                  sub_field_remaining_next = sfr_dec;
                  if (sub_class == SC_KEY && chars_written < 8'(KEY_BUF - 1)) begin
                    ev0  = mk(EV_KBYTE, 3'd0, 64'd0, data_byte, 1'b1, header_total);
                    has0 = 1'b1;
                    chars_written_next = chars_written + 8'd1;
                  end else if (sub_class == SC_VALUE &&
                               chars_written < 8'(VALUE_BUF - 1)) begin
                    ev0  = mk(EV_VBYTE, 3'd0, 64'd0, data_byte, 1'b1, header_total);
                    has0 = 1'b1;
                    chars_written_next = chars_written + 8'd1;
                  end
                  if (sfr_dec == 32'd0) sub_phase_next = SP_TAG;
                end
              endcase
              if (hb_err) begin
                error_latch_next = 1'b1;
              end else if (sub_dec == 32'd0) begin
                if (sub_phase_next != SP_TAG || varint_count_next != 4'd0) begin
                  error_latch_next = 1'b1;
                end else begin
                  if (has0) begin
                    ev1  = mk(EV_HDONE, 3'd0, 64'd0, 8'd0, 1'b1, header_total);
                    has1 = 1'b1;
                  end else begin
                    ev0  = mk(EV_HDONE, 3'd0, 64'd0, 8'd0, 1'b1, header_total);
                    has0 = 1'b1;
                  end
                  if (header_total < 4'(MAX_HEADERS)) header_total_next = header_total + 4'd1;
                  top_phase_next   = TP_TAG;
                  field_class_next = FC_SKIP;
                  sub_phase_next   = SP_IDLE;
                  sub_class_next   = SC_SKIP;
                end
              end
            end else begin
              if (field_class == FC_PAYLOAD) begin
                ev0  = mk(EV_PBYTE, 3'd0, 64'd0, data_byte, 1'b0, header_total);
                has0 = 1'b1;
              end
              top_remaining_next = top_dec;
              if (top_dec == 32'd0) begin
                top_phase_next   = TP_TAG;
                field_class_next = FC_SKIP;
              end
            end
          end
        endcase
      end
    end

    if (has1) ev1.last = 1'b1;
    else      ev0.last = 1'b1;
    push       = fire && has0;
    bundle.two = has1;
    bundle.e0  = ev0;
    bundle.e1  = ev1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_phase           <= TP_TAG;
      sub_phase           <= SP_IDLE;
      field_class         <= FC_SKIP;
      sub_class           <= SC_SKIP;
      varint_acc          <= '0;
      varint_count        <= '0;
      top_remaining       <= '0;
      sub_remaining       <= '0;
      sub_field_remaining <= '0;
      header_total        <= '0;
      chars_written       <= '0;
      error_latch         <= 1'b0;
    end else begin
      top_phase           <= top_phase_next;
      sub_phase           <= sub_phase_next;
      field_class         <= field_class_next;
      sub_class           <= sub_class_next;
      varint_acc          <= varint_acc_next;
      varint_count        <= varint_count_next;
      top_remaining       <= top_remaining_next;
      sub_remaining       <= sub_remaining_next;
      sub_field_remaining <= sub_field_remaining_next;
      header_total        <= header_total_next;
      chars_written       <= chars_written_next;
      error_latch         <= error_latch_next;
    end
  end

endmodule

// ----- hw/rtl/pfd_queue.sv -----
// ----------------------------------------------------------------------------
// pfd_queue: event bundle queue
// Short first-in first-out queue of event bundles between the decoder
// front end and the output stage.
// ----------------------------------------------------------------------------
module pfd_queue import pfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  pfd_bundle_t wdata,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output pfd_bundle_t rdata
);

  pfd_bundle_t       slots [QDEPTH];
  logic [QAW-1:0]    wptr, rptr;
  logic [QAW:0]      count;

  assign full      = (count == (QAW+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign rdata     = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + QAW'(1);
      if (pop)  rptr <= rptr + QAW'(1);
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

// ----- hw/rtl/pfd_back.sv -----
// ----------------------------------------------------------------------------
// pfd_back: event output stage
// Takes bundles from the queue and hands their events out one word at a
// time through an output register and a pending slot.
// ----------------------------------------------------------------------------
module pfd_back import pfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  pfd_bundle_t q_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output pfd_event_t  out_ev
);

  logic       pend_valid;
  pfd_event_t pend_ev;
  logic       advance;

  assign advance = !out_valid || out_ready;
  assign pop     = advance && !pend_valid && q_valid;

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pend_valid) begin
        out_ev <= pend_ev;
      end else if (q_valid) begin
        out_ev  <= q_data.e0;
        pend_ev <= q_data.e1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (advance) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        out_valid  <= q_valid;
        pend_valid <= q_valid && q_data.two;
      end
    end
  end

endmodule

// ----- hw/rtl/protobuf_frame_field_decoder.sv -----
// ----------------------------------------------------------------------------
// protobuf_frame_field_decoder: streaming protobuf frame field decoder
// Decodes protobuf frames byte by byte into scalar, payload and header
// events with a frame end status word.
// ----------------------------------------------------------------------------
// The block takes one input word per clock while its queue is not full: a
// frame byte, or an end word that closes the frame and yields a frame end
// event with the status. Each byte yields zero, one or two events, kept as
// one bundle in a four-entry queue; the output stage sends one event per
// cycle while the receiver is ready, so the sustained rate is one input
// word per cycle, less only where a byte yields two events (a header that
// closes on a key or value byte or on an empty key or value string, or an
// empty header), whose second event holds the output. A first event passes
// a queue slot and the output register. Malformed input latches an error;
// later bytes give no events until the end word, whose status then reads 1.
module protobuf_frame_field_decoder import pfd_pkg::*; #(
  parameter int MAX_HEADERS = 8,
  parameter int KEY_BUF     = 64,
  parameter int VALUE_BUF   = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // data_byte
  input  logic [0:0]         s_axis_tuser,   // kind
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // field_id, value, out_byte,
                                             // header_index, header_stored, status
  output logic [3:0]         m_axis_tuser,   // event_res
  output logic               m_axis_tlast
);

  logic        push, q_full, q_valid, pop;
  pfd_bundle_t wbundle, rbundle;
  pfd_event_t  ev;

  pfd_front #(
    .MAX_HEADERS(MAX_HEADERS),
    .KEY_BUF    (KEY_BUF),
    .VALUE_BUF  (VALUE_BUF)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .kind     (s_axis_tuser[0]),
    .data_byte(s_axis_tdata),
    .q_full   (q_full),
    .push     (push),
    .bundle   (wbundle)
  );

  pfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (wbundle),
    .full     (q_full),
    .pop      (pop),
    .not_empty(q_valid),
    .rdata    (rbundle)
  );

  pfd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (rbundle),
    .pop      (pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_ev   (ev)
  );

  assign m_axis_tdata = {7'd0, ev.status, ev.hstored, ev.hidx, ev.ob, ev.value, ev.fid};
  assign m_axis_tuser = ev.ev;
  assign m_axis_tlast = ev.last;

endmodule

// ----- hw/rtl/pfd_checker.sv -----
// ----------------------------------------------------------------------------
// pfd_checker: port level checks for the frame field decoder
// Watches the output stream for stalls and for field use by event kind.
// ----------------------------------------------------------------------------
module pfd_checker import pfd_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [3:0]         m_axis_tuser,
  input logic               m_axis_tlast
);

  // stalled word stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped while stalled");

  // frame end closes its input word
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == EV_END |-> m_axis_tlast)
    else $error("frame end without last");

  // status only on frame end
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != EV_END |-> !m_axis_tdata[80])
    else $error("status outside frame end");

  // field number only on scalar words
  a_fid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != EV_SCALAR |-> m_axis_tdata[2:0] == 3'd0)
    else $error("field number on non scalar word");

endmodule

bind protobuf_frame_field_decoder pfd_checker u_pfd_checker (.*);
